[rtl/sitda_pkg.sv]
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BCNT_W     = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

[rtl/sitda_in_if.sv]
interface sitda_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sitda_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/sitda_out_if.sv]
interface sitda_out_if;
  logic                          valid;
  logic                          ready;
  logic [sitda_pkg::CHAR_W-1:0]  character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[rtl/signed_int_to_decimal_ascii_top.sv]
// Input is taken only in the idle state, so a new number is accepted only after
//   the last digit of the previous one has entered the output stage. Conversion is
//   a bit-serial double-dabble pass over the 32 input bits; then leading zero
//   digits are skipped and the minus sign and the digits are emitted.
// Characters leave a registered output stage one per cycle while ready is high.
// Reset: synchronous, active low; clears the state machine and output valid.
module signed_int_to_decimal_ascii_top (
  input  logic              clk,
  input  logic              rst_n,
  sitda_in_if.sink          in_if,
  sitda_out_if.source       out_if
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                            state_r, state_nxt;
  logic                              neg_r, neg_nxt;
  logic [sitda_pkg::VALUE_W-1:0]     mag_r, mag_nxt;
  logic [sitda_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [sitda_pkg::BCNT_W-1:0]      bcnt_r, bcnt_nxt;
  logic [sitda_pkg::DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              in_accept;
  logic                              slot_free;
  logic [3:0]                        top_digit;
  logic [sitda_pkg::BCD_W-1:0]       bcd_adj;

  assign in_if.ready      = (state_r == ST_IDLE);
  assign in_accept        = in_if.valid && in_if.ready;
  assign slot_free        = !out_valid_r || out_if.ready;
  assign top_digit        = bcd_r[sitda_pkg::BCD_W-1 -: 4];
  assign bcd_adj          = sitda_pkg::dabble(bcd_r);

  assign out_if.valid     = out_valid_r;
  assign out_if.character = out_char_r;
  assign out_if.last      = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bcnt_nxt      = bcnt_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          neg_nxt   = in_if.value[sitda_pkg::VALUE_W-1];
          mag_nxt   = in_if.value[sitda_pkg::VALUE_W-1] ?
                      (~in_if.value + 1'b1) : in_if.value;
          bcd_nxt   = '0;
          bcnt_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt  = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_r[sitda_pkg::VALUE_W-1]};
        mag_nxt  = {mag_r[sitda_pkg::VALUE_W-2:0], 1'b0};
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == sitda_pkg::BCNT_W'(sitda_pkg::VALUE_W - 1)) begin
          dcnt_nxt  = sitda_pkg::DCNT_W'(sitda_pkg::NUM_DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == 4'd0) && (dcnt_r > sitda_pkg::DCNT_W'(1))) begin
          bcd_nxt  = {bcd_r[sitda_pkg::BCD_W-5:0], 4'd0};
          dcnt_nxt = dcnt_r - 1'b1;
        end else if (neg_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sitda_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
            neg_nxt       = 1'b0;
            state_nxt     = ST_EMIT;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sitda_pkg::CHAR_ZERO + {3'd0, top_digit};
          out_last_nxt  = (dcnt_r == sitda_pkg::DCNT_W'(1));
          bcd_nxt       = {bcd_r[sitda_pkg::BCD_W-5:0], 4'd0};
          dcnt_nxt      = dcnt_r - 1'b1;
          if (dcnt_r == sitda_pkg::DCNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bcnt_r     <= bcnt_nxt;
    dcnt_r     <= dcnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_CONV))
    else $error("conversion did not start after input transaction");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && slot_free && (dcnt_r == sitda_pkg::DCNT_W'(1)))
    |=> ((state_r == ST_IDLE) && out_valid_r && out_last_r))
    else $error("final digit not flagged or state not idle");

  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SKIP) || (state_r == ST_EMIT)) |-> (dcnt_r != '0))
    else $error("digit count empty while emitting");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r == sitda_pkg::CHAR_MINUS) ||
                     ((out_char_r >= sitda_pkg::CHAR_ZERO) &&
                      (out_char_r <= sitda_pkg::CHAR_NINE))))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == sitda_pkg::CHAR_MINUS)) |-> !out_last_r)
    else $error("minus sign flagged as last");
`endif

endmodule
